/* rtl/core/tdq_pkg.sv */
// Shared types and constants of the threshold on/off delay qualifier.
package tdq_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SMP_W        = 24;
    localparam int TIME_W       = 32;
    localparam int THR_W        = 23;
    localparam int DLY_W        = 24;
    localparam int ST_W         = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    // Per-channel status codes as they appear on the result
    typedef enum logic [ST_W-1:0] {
        ST_INIT     = 3'd0,
        ST_OFF      = 3'd1,
        ST_STARTING = 3'd2,
        ST_ON       = 3'd3,
        ST_STOPPING = 3'd4
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_ON_DELAY  = 2'd1,
        CFG_OFF_DELAY = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [DLY_W-1:0] on_delay;
        logic [DLY_W-1:0] off_delay;
    } t_cfg;

    // One entry of the per-channel state memory
    typedef struct packed {
        t_status           status;
        logic [TIME_W-1:0] last;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{status: ST_INIT, last: '0};

    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
    } t_ram_rd;

    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
        t_entry              data;
    } t_ram_wr;

endpackage

/* rtl/core/tdq_intf.sv */
// Handshake channel interfaces: sample input, result output and configuration write.
interface tdq_in_if;
    import tdq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          channel;
    logic signed [SMP_W-1:0]  sample_value;
    logic [TIME_W-1:0]        time_ms;

    modport source (output valid, output channel, output sample_value, output time_ms,
                    input ready);
    modport sink   (input valid, input channel, input sample_value, input time_ms,
                    output ready);
endinterface

interface tdq_out_if;
    import tdq_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_channel;
    logic [ST_W-1:0] new_status;
    logic            publish_event;
    logic            switched_on;

    modport source (output valid, output out_channel, output new_status,
                    output publish_event, output switched_on, input ready);
    modport sink   (input valid, input out_channel, input new_status,
                    input publish_event, input switched_on, output ready);
endinterface

interface tdq_cfg_if;
    import tdq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/tdq_cfg_regs.sv */
// Configuration register file: threshold, on delay and off delay.
module tdq_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tdq_cfg_if.sink        i_cfg,
    output tdq_pkg::t_cfg  o_cfg
);
    import tdq_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic [DLY_W-1:0] r_on_dly;
    logic [DLY_W-1:0] r_off_dly;

    // Always take a write
    assign i_cfg.ready = 1'b1;

    // Update the addressed register, drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_on_dly  <= '0;
            r_off_dly <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_THRESHOLD: r_thr     <= i_cfg.data[THR_W-1:0];
                CFG_ON_DELAY:  r_on_dly  <= i_cfg.data[DLY_W-1:0];
                CFG_OFF_DELAY: r_off_dly <= i_cfg.data[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = '{threshold: r_thr, on_delay: r_on_dly, off_delay: r_off_dly};

endmodule

/* rtl/core/tdq_state_ram.sv */
// Per-channel state memory with registered read and reset-to-init valid bits.
module tdq_state_ram (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tdq_pkg::t_ram_rd i_rd,
    input  tdq_pkg::t_ram_wr i_wr,
    output tdq_pkg::t_entry  o_rd_data
);
    import tdq_pkg::*;

    t_entry                  r_mem [NUM_CHANNELS];
    t_entry                  r_rd_data;
    logic [NUM_CHANNELS-1:0] r_vld;
    logic                    r_rd_vld;

    // Write and read the storage array, read returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx];
        end
    end

    // Track which entries hold written data since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.idx];
            end
        end
    end

    // An entry never written reads as the reset state
    assign o_rd_data = r_rd_vld ? r_rd_data : ENTRY_RESET;

endmodule

/* rtl/core/tdq_pipe.sv */
// Item pipeline: read state, qualify level against delays, write back, register result.
module tdq_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tdq_pkg::t_cfg    i_cfg,
    tdq_in_if.sink           i_in,
    tdq_out_if.source        o_out,
    output tdq_pkg::t_ram_rd o_rd,
    output tdq_pkg::t_ram_wr o_wr,
    input  tdq_pkg::t_entry  i_rd_data
);
    import tdq_pkg::*;

    logic              in_acc;
    logic              s1_adv;
    logic [SMP_W-1:0]  raw;
    logic [SMP_W-1:0]  mag;
    logic              n_high;
    logic              in_rng;
    logic [CH_IDX_W-1:0] in_idx;

    logic                r_s1_valid;
    logic [CH_W-1:0]     r_s1_ch;
    logic [CH_IDX_W-1:0] r_s1_idx;
    logic                r_s1_rng;
    logic                r_s1_high;
    logic [TIME_W-1:0]   r_s1_time;
    logic                r_fwd;
    t_entry              r_fwd_data;

    t_entry            cur;
    t_status           st;
    logic [TIME_W-1:0] last;
    logic              pub;
    logic              dir_on;
    t_entry            n_entry;

    logic            r_out_valid;
    logic [CH_W-1:0] r_out_ch;
    t_status         r_out_st;
    logic            r_out_pub;
    logic            r_out_dir;

    // Handshake: stage 1 moves on when the output register is free or being emptied
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    // Level detect on entry: magnitude against threshold
    assign raw    = i_in.sample_value;
    assign mag    = raw[SMP_W-1] ? (~raw + SMP_W'(1)) : raw;
    assign n_high = mag >= {{(SMP_W-THR_W){1'b0}}, i_cfg.threshold};
    assign in_rng = 32'(i_in.channel) < 32'(NUM_CHANNELS);
    assign in_idx = CH_IDX_W'(i_in.channel);

    // Issue the state read together with the accept
    assign o_rd = '{en: in_acc, idx: in_idx};

    // Capture the item into stage 1, note a write to the same entry in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_adv && r_s1_rng && (r_s1_idx == in_idx);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ch    <= i_in.channel;
            r_s1_idx   <= in_idx;
            r_s1_rng   <= in_rng;
            r_s1_high  <= n_high;
            r_s1_time  <= i_in.time_ms;
            r_fwd_data <= n_entry;
        end
    end

    // Evaluate the states in order init, off, on, starting, stopping
    always_comb begin
        cur    = r_fwd ? r_fwd_data : i_rd_data;
        last   = cur.last;
        pub    = 1'b0;
        dir_on = 1'b0;
        case (cur.status)
            ST_OFF, ST_STARTING, ST_ON, ST_STOPPING: st = cur.status;
            default: st = ST_INIT;
        endcase

        if (st == ST_INIT) begin
            st   = r_s1_high ? ST_STARTING : ST_STOPPING;
            last = r_s1_time;
        end
        if (st == ST_OFF && r_s1_high) begin
            st   = ST_STARTING;
            last = r_s1_time;
        end
        if (st == ST_ON && !r_s1_high) begin
            st   = ST_STOPPING;
            last = r_s1_time;
        end
        if (st == ST_STARTING) begin
            if (r_s1_high) begin
                if ((r_s1_time - last) >= {{(TIME_W-DLY_W){1'b0}}, i_cfg.on_delay}) begin
                    st     = ST_ON;
                    last   = r_s1_time;
                    pub    = 1'b1;
                    dir_on = 1'b1;
                end
            end else begin
                st = ST_OFF;
            end
        end
        if (st == ST_STOPPING) begin
            if (!r_s1_high) begin
                if ((r_s1_time - last) >= {{(TIME_W-DLY_W){1'b0}}, i_cfg.off_delay}) begin
                    st   = ST_OFF;
                    last = r_s1_time;
                    pub  = 1'b1;
                end
            end else begin
                st = ST_ON;
            end
        end

        // A channel outside the table reports init and changes nothing
        if (!r_s1_rng) begin
            st     = ST_INIT;
            pub    = 1'b0;
            dir_on = 1'b0;
        end
        n_entry = '{status: st, last: last};
    end

    // Write back as the item leaves stage 1
    assign o_wr = '{en: s1_adv && r_s1_rng, idx: r_s1_idx, data: n_entry};

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_ch  <= r_s1_ch;
            r_out_st  <= st;
            r_out_pub <= pub;
            r_out_dir <= dir_on;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_channel   = r_out_ch;
    assign o_out.new_status    = r_out_st;
    assign o_out.publish_event = r_out_pub;
    assign o_out.switched_on   = r_out_dir;

endmodule

/* rtl/core/threshold_on_off_delay_qualifier.sv */
// Threshold on/off delay qualifier: takes one item per cycle while results are taken;
// each item passes stage 1, with the registered state read, and then the output register.
// Each item names a channel, a signed sample and a millisecond timestamp. The sample's
// magnitude is compared with the threshold and a per-channel state machine (init, off,
// starting, on, stopping) confirms a switch on or off only after the level has held for
// the on or off delay; elapsed time wraps modulo 2^32 and a zero delay confirms at once.
// Every item yields one result with the new status and, on a confirmed change, a publish
// flag and its direction. Items on the same channel may follow back to back: the
// written-back state is forwarded to the next read. No clearing pass follows reset; the
// state of all channels starts at init. Write configuration only while no item is pending.
module threshold_on_off_delay_qualifier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tdq_cfg_if.sink   i_cfg,
    tdq_in_if.sink    i_in,
    tdq_out_if.source o_out
);
    import tdq_pkg::*;

    t_cfg    cfg;
    t_ram_rd rd;
    t_ram_wr wr;
    t_entry  rd_data;

    // Configuration registers
    tdq_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Per-channel state
    tdq_state_ram u_state_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd),
        .i_wr      (wr),
        .o_rd_data (rd_data)
    );

    // Read-modify-write pipeline
    tdq_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_rd      (rd),
        .o_wr      (wr),
        .i_rd_data (rd_data)
    );

endmodule
